@@ rtl/qcg_pkg.sv @@
// shared widths, constants and types of the quad cell geometry unit
// used by qcg_front, qcg_back and the top level; no dependencies
package qcg_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CW = 32;           // coordinate width
  localparam int DW = CW + 1;       // coordinate difference
  localparam int NW = 2 * DW;       // squared face length
  localparam int RW = NW / 2;       // integer root of a squared length
  localparam int LW = 34;           // face length output
  localparam int AW = 48;           // area and inverse area
  localparam int DQW = 32;          // normal quotient / output
  localparam int DVW = 64;          // normal dividend
  localparam int NORM_SHIFT = 30;   // q1.30 normals
  localparam int ROOT_STEPS = NW / 2;
  localparam int DIV_STEPS = DQW;
  localparam int CNTW = 6;

  localparam logic [DQW-1:0] ONE_Q30 = DQW'(1) << NORM_SHIFT;

  localparam int CELL_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  typedef struct packed {
    logic [3:0][DW-1:0] dx;
    logic [3:0][DW-1:0] dy;
    logic [3:0][NW-1:0] nsq;
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
    logic [CW-1:0]      cz;
    logic [AW-1:0]      area;
  } cell_t;

  typedef struct packed {
    logic [1:0]     face_index;
    logic [LW-1:0]  face_length;
    logic [DQW-1:0] normal_x;
    logic [DQW-1:0] normal_y;
    logic [CW-1:0]  center_x;
    logic [CW-1:0]  center_y;
    logic [CW-1:0]  center_z;
    logic [AW-1:0]  cell_area;
    logic [AW-1:0]  inverse_area;
    logic           degenerate;
    logic           last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROOT,
    BK_LOAD,
    BK_DIV,
    BK_WAIT,
    BK_EMIT
  } bk_state_t;

endpackage

@@ rtl/qcg_fifo.sv @@
// small flop-based first-in first-out queue
// generic width and depth; no package dependencies
module qcg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CNW-1:0] cnt_r;
  logic           wr, rd;

  assign full    = (cnt_r == CNW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + CNW'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ rtl/qcg_front.sv @@
// front part: accepts a cell, forms differences, centroid, squared lengths and area
// three register stages; depends on qcg_pkg
module qcg_front #(
  parameter int FRAC_BITS = qcg_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [11:0][qcg_pkg::CW-1:0] coord,
  output logic                         in_full,
  output qcg_pkg::cell_t               cell_word,
  output logic                         cell_valid,
  input  logic                         q_full
);
  import qcg_pkg::*;

  localparam int XW = NW + 1;

  logic                    adv;
  logic                    v1_r, v2_r, v3_r;
  logic [3:0][DW-1:0]      dx_c, dy_c;
  logic [2:0][CW+1:0]      csum_c;
  logic [3:0][DW-1:0]      dx1_r, dy1_r, dx2_r, dy2_r;
  logic [DW-1:0]           e1x_r, e1y_r, e2x_r, e2y_r;
  logic [2:0][CW-1:0]      c1_r, c2_r;
  logic [3:0][NW-1:0]      nsq_c, nsq2_r;
  logic signed [NW-1:0]    p1_r, p2_r;
  logic signed [XW-1:0]    cr_c;
  logic [XW-1:0]           mag_c, rnd_c, sh_c;
  logic [AW-1:0]           area_c;
  cell_t                   cell_r;

  function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [CW+1:0] sx2(input logic [CW-1:0] a);
    return {{2{a[CW-1]}}, a};
  endfunction

  // face i runs from vertex (i+3)%4 to vertex i
  for (genvar i = 0; i < 4; i++) begin : g_face
    localparam int FR = (i + 3) % 4;
    assign dx_c[i] = sdiff(coord[3*i],     coord[3*FR]);
    assign dy_c[i] = sdiff(coord[3*i + 1], coord[3*FR + 1]);
  end

  // mean of four, rounded half up
  for (genvar k = 0; k < 3; k++) begin : g_ctr
    assign csum_c[k] = sx2(coord[k]) + sx2(coord[3 + k]) + sx2(coord[6 + k])
                     + sx2(coord[9 + k]) + (CW + 2)'(2);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nsq_c[i] = NW'($signed(dx1_r[i]) * $signed(dx1_r[i]))
               + NW'($signed(dy1_r[i]) * $signed(dy1_r[i]));
    end
  end

  // half the absolute diagonal cross product, rounded half up, saturated
  always_comb begin
    cr_c   = {p1_r[NW-1], p1_r} - {p2_r[NW-1], p2_r};
    mag_c  = cr_c[XW-1] ? XW'(-cr_c) : XW'(cr_c);
    rnd_c  = mag_c + (XW'(1) << FRAC_BITS);
    sh_c   = rnd_c >> (FRAC_BITS + 1);
    area_c = (|sh_c[XW-1:AW]) ? {AW{1'b1}} : sh_c[AW-1:0];
  end

  assign adv        = !v3_r || !q_full;
  assign in_full    = !adv;
  assign cell_valid = v3_r;
  assign cell_word  = cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= dx_c;
      dy1_r <= dy_c;
      e1x_r <= sdiff(coord[6], coord[0]);
      e1y_r <= sdiff(coord[7], coord[1]);
      e2x_r <= sdiff(coord[9], coord[3]);
      e2y_r <= sdiff(coord[10], coord[4]);
      for (int k = 0; k < 3; k++) begin
        c1_r[k] <= csum_c[k][CW+1:2];
      end
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      c2_r   <= c1_r;
      nsq2_r <= nsq_c;
      p1_r   <= $signed(e1x_r) * $signed(e2y_r);
      p2_r   <= $signed(e1y_r) * $signed(e2x_r);
      cell_r.dx   <= dx2_r;
      cell_r.dy   <= dy2_r;
      cell_r.nsq  <= nsq2_r;
      cell_r.cx   <= c2_r[0];
      cell_r.cy   <= c2_r[1];
      cell_r.cz   <= c2_r[2];
      cell_r.area <= area_c;
    end
  end

endmodule

@@ rtl/qcg_back.sv @@
// back part: square roots, normal divides and inverse area for one cell, then four face words
// iterative lanes under one sequencer; depends on qcg_pkg
module qcg_back #(
  parameter int FRAC_BITS = qcg_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qcg_pkg::cell_t cell_word,
  input  logic           cell_valid,
  output logic           cell_pop,
  output qcg_pkg::res_t  res,
  output logic           res_push,
  input  logic           res_full
);
  import qcg_pkg::*;

  localparam int INV_STEPS = 3 * FRAC_BITS + 2;
  localparam int IQW  = (INV_STEPS > AW + 1) ? INV_STEPS : AW + 1;
  localparam int ICW  = $clog2(INV_STEPS + 1);
  localparam int REMW = RW + 3;
  localparam int DRW  = LW + 1;

  bk_state_t st_r, st_nxt;
  logic [CNTW-1:0] cnt_r;
  logic [1:0]      fidx_r;
  cell_t           c_r;

  logic [3:0][NW-1:0]   rad_r;
  logic [3:0][REMW-1:0] rem_r, rsh_c, rtr_c;
  logic [3:0][RW-1:0]   root_r;
  logic [3:0]           rge_c;
  logic [3:0][LW-1:0]   len_r, len_c;

  logic [7:0][DRW-1:0]  drem_r, dt_c, dinit_c;
  logic [7:0][DQW-1:0]  dq_r, dqinit_c;
  logic [7:0]           dge_c, neg_r, neg_c;
  logic [7:0][DVW-1:0]  dvd_c;

  logic                 ibusy_r;
  logic [ICW-1:0]       icnt_r;
  logic [AW-1:0]        ir_r;
  logic [IQW-1:0]       iq_r, iqr_c;
  logic [AW:0]          it_c, isub_c;
  logic                 ige_c;

  logic [DQW-1:0]       qx_c, qy_c, nx_c, ny_c;
  logic [AW-1:0]        inv_c;
  logic [2:0]           lx_c, ly_c;

  function automatic logic [CW-1:0] absv(input logic [DW-1:0] d);
    logic [DW-1:0] n;
    n = -d;
    return d[DW-1] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (cell_valid) st_nxt = BK_ROOT;
      BK_ROOT: if (cnt_r == CNTW'(ROOT_STEPS - 1)) st_nxt = BK_LOAD;
      BK_LOAD: st_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CNTW'(DIV_STEPS - 1)) st_nxt = BK_WAIT;
      BK_WAIT: if (!ibusy_r) st_nxt = BK_EMIT;
      BK_EMIT: if (!res_full && fidx_r == 2'd3) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    cell_pop = (st_r == BK_IDLE) && cell_valid;
    res_push = (st_r == BK_EMIT) && !res_full;
  end

  // root lanes: two radicand bits per step
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rsh_c[i] = {rem_r[i][REMW-3:0], rad_r[i][NW-1:NW-2]};
      rtr_c[i] = REMW'({root_r[i], 2'b01});
      rge_c[i] = rsh_c[i] >= rtr_c[i];
      len_c[i] = LW'(root_r[i]) + LW'(rem_r[i] > REMW'(root_r[i]));
    end
  end

  // divider lanes: 0..3 give dy/len, 4..7 give -dx/len
  always_comb begin
    for (int f = 0; f < 4; f++) begin
      dvd_c[f]     = (DVW'(absv(c_r.dy[f])) << NORM_SHIFT) + DVW'(len_c[f] >> 1);
      dvd_c[f + 4] = (DVW'(absv(c_r.dx[f])) << NORM_SHIFT) + DVW'(len_c[f] >> 1);
      neg_c[f]     = c_r.dy[f][DW-1];
      neg_c[f + 4] = !c_r.dx[f][DW-1];
      dt_c[f]      = {drem_r[f][DRW-2:0], dq_r[f][DQW-1]};
      dt_c[f + 4]  = {drem_r[f + 4][DRW-2:0], dq_r[f + 4][DQW-1]};
      dge_c[f]     = dt_c[f] >= DRW'(len_r[f]);
      dge_c[f + 4] = dt_c[f + 4] >= DRW'(len_r[f]);
    end
    for (int j = 0; j < 8; j++) begin
      dinit_c[j]  = DRW'(dvd_c[j][DVW-1:DQW]);
      dqinit_c[j] = dvd_c[j][DQW-1:0];
    end
  end

  // inverse area, one quotient bit per step
  always_comb begin
    it_c   = {ir_r, (icnt_r == '0)};
    ige_c  = it_c >= {1'b0, c_r.area};
    isub_c = it_c - {1'b0, c_r.area};
  end

  // face word assembly
  always_comb begin
    lx_c  = {1'b0, fidx_r};
    ly_c  = {1'b1, fidx_r};
    qx_c  = (dq_r[lx_c] > ONE_Q30) ? ONE_Q30 : dq_r[lx_c];
    qy_c  = (dq_r[ly_c] > ONE_Q30) ? ONE_Q30 : dq_r[ly_c];
    nx_c  = (len_r[fidx_r] == '0) ? '0 : (neg_r[lx_c] ? -qx_c : qx_c);
    ny_c  = (len_r[fidx_r] == '0) ? '0 : (neg_r[ly_c] ? -qy_c : qy_c);
    iqr_c = (iq_r + IQW'(1)) >> 1;
    inv_c = (c_r.area == '0) ? '0 : ((|iqr_c[IQW-1:AW]) ? {AW{1'b1}} : iqr_c[AW-1:0]);
    res.face_index   = fidx_r;
    res.face_length  = len_r[fidx_r];
    res.normal_x     = nx_c;
    res.normal_y     = ny_c;
    res.center_x     = c_r.cx;
    res.center_y     = c_r.cy;
    res.center_z     = c_r.cz;
    res.cell_area    = c_r.area;
    res.inverse_area = inv_c;
    res.degenerate   = (c_r.area == '0) || (len_r[fidx_r] == '0);
    res.last         = (fidx_r == 2'd3);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      cnt_r   <= '0;
      fidx_r  <= '0;
      ibusy_r <= 1'b0;
      icnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        BK_ROOT, BK_DIV: cnt_r <= cnt_r + CNTW'(1);
        default:         cnt_r <= '0;
      endcase
      if (st_r == BK_IDLE) begin
        fidx_r <= '0;
      end else if (res_push) begin
        fidx_r <= fidx_r + 2'd1;
      end
      if (cell_pop) begin
        ibusy_r <= 1'b1;
        icnt_r  <= '0;
      end else if (ibusy_r) begin
        icnt_r <= icnt_r + ICW'(1);
        if (icnt_r == ICW'(INV_STEPS - 1)) begin
          ibusy_r <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cell_pop) begin
      c_r    <= cell_word;
      rad_r  <= cell_word.nsq;
      rem_r  <= '0;
      root_r <= '0;
      ir_r   <= '0;
      iq_r   <= '0;
    end else begin
      if (st_r == BK_ROOT) begin
        for (int i = 0; i < 4; i++) begin
          rad_r[i]  <= rad_r[i] << 2;
          rem_r[i]  <= rge_c[i] ? rsh_c[i] - rtr_c[i] : rsh_c[i];
          root_r[i] <= {root_r[i][RW-2:0], rge_c[i]};
        end
      end
      if (ibusy_r) begin
        ir_r <= ige_c ? isub_c[AW-1:0] : it_c[AW-1:0];
        iq_r <= {iq_r[IQW-2:0], ige_c};
      end
    end
    if (st_r == BK_LOAD) begin
      len_r  <= len_c;
      drem_r <= dinit_c;
      dq_r   <= dqinit_c;
      neg_r  <= neg_c;
    end else if (st_r == BK_DIV) begin
      for (int j = 0; j < 8; j++) begin
        drem_r[j] <= dge_c[j] ? dt_c[j] - DRW'(len_r[j[1:0]]) : dt_c[j];
        dq_r[j]   <= {dq_r[j][DQW-2:0], dge_c[j]};
      end
    end
  end

endmodule

@@ rtl/quad_cell_geometry_unit.sv @@
// top level of the quad cell geometry unit
// instantiates qcg_front, qcg_fifo and qcg_back; depends on qcg_pkg
//
// One cell (four vertices, signed fixed point with FRAC_BITS fraction bits) is pushed as one
// word and comes back as four face words in the order (v3,v0), (v0,v1), (v1,v2), (v2,v3),
// the fourth carrying last. Every face word repeats the centroid, area and inverse area.
// The front takes a word each cycle while not stalled by a full cell queue, through three stages
// (differences and centroid, squares and diagonal products, area) into a two-deep cell queue.
// The back works one cell at a time: square root on four lanes, a load state, normal division
// on eight lanes, a wait on the inverse area divider, then the four face words written into a
// four-deep result queue, then an idle state to take the next cell; the inverse area divider
// (3*FRAC_BITS+2 steps) runs beside it and stretches the wait when it needs longer. That
// sequence sets the sustained rate, and the back takes no new cell until it is done. The
// front keeps accepting while the back is busy until the cell queue and its stages fill,
// and the back keeps going while up to four results wait to be popped.
module quad_cell_geometry_unit #(
  parameter int FRAC_BITS = qcg_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input side
  input  logic                           in_push,
  output logic                           in_full,
  input  logic signed [qcg_pkg::CW-1:0]  in_x0,
  input  logic signed [qcg_pkg::CW-1:0]  in_y0,
  input  logic signed [qcg_pkg::CW-1:0]  in_z0,
  input  logic signed [qcg_pkg::CW-1:0]  in_x1,
  input  logic signed [qcg_pkg::CW-1:0]  in_y1,
  input  logic signed [qcg_pkg::CW-1:0]  in_z1,
  input  logic signed [qcg_pkg::CW-1:0]  in_x2,
  input  logic signed [qcg_pkg::CW-1:0]  in_y2,
  input  logic signed [qcg_pkg::CW-1:0]  in_z2,
  input  logic signed [qcg_pkg::CW-1:0]  in_x3,
  input  logic signed [qcg_pkg::CW-1:0]  in_y3,
  input  logic signed [qcg_pkg::CW-1:0]  in_z3,
  // result side
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [1:0]                     out_face_index,
  output logic [qcg_pkg::LW-1:0]         out_face_length,
  output logic signed [qcg_pkg::DQW-1:0] out_normal_x,
  output logic signed [qcg_pkg::DQW-1:0] out_normal_y,
  output logic signed [qcg_pkg::CW-1:0]  out_center_x,
  output logic signed [qcg_pkg::CW-1:0]  out_center_y,
  output logic signed [qcg_pkg::CW-1:0]  out_center_z,
  output logic [qcg_pkg::AW-1:0]         out_cell_area,
  output logic [qcg_pkg::AW-1:0]         out_inverse_area,
  output logic                           out_degenerate,
  output logic                           out_last
);
  import qcg_pkg::*;

  logic [11:0][CW-1:0] coord;
  cell_t fr_cell, q_cell;
  logic  fr_valid, cq_full, cq_empty, cq_pop;
  res_t  bk_res, rq_res;
  logic  bk_push, rq_full;

  // vertex k occupies slots 3k (x), 3k+1 (y), 3k+2 (z)
  assign coord = {in_z3, in_y3, in_x3, in_z2, in_y2, in_x2,
                  in_z1, in_y1, in_x1, in_z0, in_y0, in_x0};

  qcg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .coord      (coord),
    .in_full    (in_full),
    .cell_word  (fr_cell),
    .cell_valid (fr_valid),
    .q_full     (cq_full)
  );

  // cell queue between front and back
  qcg_fifo #(.W($bits(cell_t)), .DEPTH(CELL_Q_DEPTH)) u_cell_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid),
    .wr_data (fr_cell),
    .full    (cq_full),
    .rd_en   (cq_pop),
    .rd_data (q_cell),
    .empty   (cq_empty)
  );

  qcg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_word  (q_cell),
    .cell_valid (!cq_empty),
    .cell_pop   (cq_pop),
    .res        (bk_res),
    .res_push   (bk_push),
    .res_full   (rq_full)
  );

  // result queue holds one whole cell of face words
  qcg_fifo #(.W($bits(res_t)), .DEPTH(RES_Q_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bk_push),
    .wr_data (bk_res),
    .full    (rq_full),
    .rd_en   (out_pop),
    .rd_data (rq_res),
    .empty   (out_empty)
  );

  assign out_face_index   = rq_res.face_index;
  assign out_face_length  = rq_res.face_length;
  assign out_normal_x     = rq_res.normal_x;
  assign out_normal_y     = rq_res.normal_y;
  assign out_center_x     = rq_res.center_x;
  assign out_center_y     = rq_res.center_y;
  assign out_center_z     = rq_res.center_z;
  assign out_cell_area    = rq_res.cell_area;
  assign out_inverse_area = rq_res.inverse_area;
  assign out_degenerate   = rq_res.degenerate;
  assign out_last         = rq_res.last;

endmodule

@@ rtl/qcg_checker.sv @@
// port-level checks of the quad cell geometry unit, bound to the top level
// depends on the top level's ports only
module qcg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [1:0]         out_face_index,
  input logic [33:0]        out_face_length,
  input logic signed [31:0] out_normal_x,
  input logic signed [31:0] out_normal_y,
  input logic [47:0]        out_cell_area,
  input logic [47:0]        out_inverse_area,
  input logic               out_degenerate,
  input logic               out_last
);

  // faces of a cell come out in order
  a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=>
      (out_empty || out_face_index == $past(out_face_index) + 2'd1))
    else $error("face word out of order");

  a_last_face: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_face_index != 2'd3))
    else $error("fourth face without last");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_face_length == '0) |->
      (out_degenerate && out_normal_x == '0 && out_normal_y == '0))
    else $error("zero length face not flagged");

  a_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_cell_area == '0) |-> (out_degenerate && out_inverse_area == '0))
    else $error("zero area cell not flagged");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_normal_x <= 32'sh4000_0000 && out_normal_x >= -32'sh4000_0000 &&
                    out_normal_y <= 32'sh4000_0000 && out_normal_y >= -32'sh4000_0000))
    else $error("normal component beyond one");

endmodule

bind quad_cell_geometry_unit qcg_checker u_qcg_checker (.*);
